// ===== hdl/vt4x4_pkg.sv =====
package vt4x4_pkg;

    localparam int DIM       = 4;
    localparam int NUM_ELEMS = DIM * DIM;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;
    localparam int IDX_W     = $clog2(DIM);
    localparam int ELEM_IDX_W = $clog2(NUM_ELEMS);

    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;

    typedef logic signed [DATA_W-1:0] t_q16;

    typedef struct packed {
        t_q16 value;
        logic ovf;
    } t_lane_res;

endpackage

// ===== hdl/vt4x4_mstore.sv =====
module vt4x4_mstore (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [vt4x4_pkg::IDX_W-1:0]          i_row,
    input  logic [vt4x4_pkg::IDX_W-1:0]          i_col,
    input  vt4x4_pkg::t_q16                      i_data,
    output vt4x4_pkg::t_q16                      o_elems [vt4x4_pkg::NUM_ELEMS]
);

    vt4x4_pkg::t_q16 r_elem [vt4x4_pkg::NUM_ELEMS];
    logic [vt4x4_pkg::ELEM_IDX_W-1:0] waddr;

    assign waddr = {i_row, i_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vt4x4_pkg::NUM_ELEMS; i++) begin
                r_elem[i] <= '0;
            end
        end else if (i_we) begin
            r_elem[waddr] <= i_data;
        end
    end

    assign o_elems = r_elem;

endmodule

// ===== hdl/vt4x4_lane.sv =====
module vt4x4_lane (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  vt4x4_pkg::t_q16       i_vec [vt4x4_pkg::DIM],
    input  vt4x4_pkg::t_q16       i_col [vt4x4_pkg::DIM],
    output vt4x4_pkg::t_lane_res  o_res
);

    localparam int SUM_W = vt4x4_pkg::SUM_W;
    localparam int Q_W   = SUM_W - vt4x4_pkg::FRAC_W;
    localparam logic signed [Q_W-1:0] QMAX = Q_W'(2147483647);
    localparam logic signed [Q_W-1:0] QMIN = -(Q_W'(64'sd2147483648));
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (vt4x4_pkg::FRAC_W - 1);

    logic signed [vt4x4_pkg::PROD_W-1:0] r_prod [vt4x4_pkg::DIM];
    logic signed [SUM_W-1:0]             sum;
    logic signed [SUM_W-1:0]             rnd;
    logic signed [Q_W-1:0]               q;
    vt4x4_pkg::t_lane_res                n_res;
    vt4x4_pkg::t_lane_res                r_res;

    // stage 1: one multiplier per row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < vt4x4_pkg::DIM; r++) begin
                r_prod[r] <= i_vec[r] * i_col[r];
            end
        end
    end

    // stage 2: exact sum, round half up, saturate
    always_comb begin
        sum = '0;
        for (int r = 0; r < vt4x4_pkg::DIM; r++) begin
            sum = sum + SUM_W'(r_prod[r]);
        end
        rnd = sum + HALF;
        q   = rnd[SUM_W-1:vt4x4_pkg::FRAC_W];
        if (q > QMAX) begin
            n_res.value = vt4x4_pkg::t_q16'(QMAX);
            n_res.ovf   = 1'b1;
        end else if (q < QMIN) begin
            n_res.value = vt4x4_pkg::t_q16'(QMIN);
            n_res.ovf   = 1'b1;
        end else begin
            n_res.value = q[vt4x4_pkg::DATA_W-1:0];
            n_res.ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== hdl/vt4x4_merge.sv =====
module vt4x4_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  vt4x4_pkg::t_lane_res  i_lane [vt4x4_pkg::DIM],
    input  logic                  i_stall,
    output logic                  o_valid,
    output vt4x4_pkg::t_q16       o_comp [vt4x4_pkg::DIM],
    output logic                  o_overflow,
    output logic                  o_full
);

    vt4x4_pkg::t_q16 n_comp [vt4x4_pkg::DIM];
    logic            n_ovf;
    vt4x4_pkg::t_q16 r_out_comp [vt4x4_pkg::DIM];
    logic            r_out_ovf;
    logic            r_out_valid;
    vt4x4_pkg::t_q16 r_skid_comp [vt4x4_pkg::DIM];
    logic            r_skid_ovf;
    logic            r_skid_valid;
    logic            take;

    always_comb begin
        n_ovf = 1'b0;
        for (int c = 0; c < vt4x4_pkg::DIM; c++) begin
            n_comp[c] = i_lane[c].value;
            n_ovf     = n_ovf | i_lane[c].ovf;
        end
    end

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_comp <= n_comp;
                r_out_ovf  <= n_ovf;
            end else begin
                r_skid_comp <= n_comp;
                r_skid_ovf  <= n_ovf;
            end
        end else if (take && r_skid_valid) begin
            r_out_comp <= r_skid_comp;
            r_out_ovf  <= r_skid_ovf;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_comp     = r_out_comp;
    assign o_overflow = r_out_ovf;
    assign o_full     = r_skid_valid;

endmodule

// ===== hdl/vertex_transform_4x4.sv =====
// Row vector times 4x4 matrix, signed Q16.16.
// Input channel: i_valid / o_stall. A request with i_mode = 0 writes i_load_value
// into element (i_row_index, i_col_index) and produces no result. A request with
// i_mode = 1 transforms (i_vec_x, i_vec_y, i_vec_z, i_vec_w) with the matrix as it
// stands after all earlier requests.
// Output channel: o_valid / i_stall, one result per transform request, in order.
// Each component is rounded half up and saturated; o_overflow flags saturation.
// An accepted request passes the multiply stage, the sum/round stage, then the
// output register. Throughput: one request per cycle while o_stall is low, set
// by four lanes of four multipliers.
// When the receiver stalls, one extra result is caught in a skid register; once
// that is occupied o_stall rises and the pipeline holds until it drains.
// Reset (synchronous, active low) clears the matrix to zero and empties the
// pipeline and output registers.
module vertex_transform_4x4 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic [vt4x4_pkg::IDX_W-1:0]         i_row_index,
    input  logic [vt4x4_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [vt4x4_pkg::DATA_W-1:0] i_load_value,
    input  logic signed [vt4x4_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [vt4x4_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [vt4x4_pkg::DATA_W-1:0] i_vec_z,
    input  logic signed [vt4x4_pkg::DATA_W-1:0] i_vec_w,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [vt4x4_pkg::DATA_W-1:0] o_out_x,
    output logic signed [vt4x4_pkg::DATA_W-1:0] o_out_y,
    output logic signed [vt4x4_pkg::DATA_W-1:0] o_out_z,
    output logic signed [vt4x4_pkg::DATA_W-1:0] o_out_w,
    output logic                                o_overflow
);

    logic                 accept;
    logic                 en;
    logic                 full;
    logic                 r_v1;
    logic                 r_v2;
    vt4x4_pkg::t_q16      elems [vt4x4_pkg::NUM_ELEMS];
    vt4x4_pkg::t_q16      vec   [vt4x4_pkg::DIM];
    vt4x4_pkg::t_lane_res lane_res [vt4x4_pkg::DIM];
    vt4x4_pkg::t_q16      comp  [vt4x4_pkg::DIM];

    assign en      = !full;
    assign o_stall = full;
    assign accept  = i_valid && en;

    assign vec[0] = i_vec_x;
    assign vec[1] = i_vec_y;
    assign vec[2] = i_vec_z;
    assign vec[3] = i_vec_w;

    vt4x4_mstore u_mstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && (i_mode == vt4x4_pkg::MODE_LOAD)),
        .i_row   (i_row_index),
        .i_col   (i_col_index),
        .i_data  (i_load_value),
        .o_elems (elems)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && (i_mode == vt4x4_pkg::MODE_TRANSFORM);
            r_v2 <= r_v1;
        end
    end

    for (genvar c = 0; c < vt4x4_pkg::DIM; c++) begin : g_lane
        vt4x4_pkg::t_q16 col [vt4x4_pkg::DIM];

        for (genvar r = 0; r < vt4x4_pkg::DIM; r++) begin : g_row
            assign col[r] = elems[r * vt4x4_pkg::DIM + c];
        end

        vt4x4_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (vec),
            .i_col (col),
            .o_res (lane_res[c])
        );
    end

    vt4x4_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_v2 && en),
        .i_lane     (lane_res),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_comp     (comp),
        .o_overflow (o_overflow),
        .o_full     (full)
    );

    assign o_out_x = comp[0];
    assign o_out_y = comp[1];
    assign o_out_z = comp[2];
    assign o_out_w = comp[3];

endmodule

// ===== dv/testbench.sv =====
module testbench;

    localparam int   CYCLE_LIMIT = 200000;
    localparam int   LONG_HOLD   = 64;
    localparam int   SETTLE      = 8;
    localparam vt4x4_pkg::t_q16 Q_ONE = 32'sh0001_0000;
    localparam vt4x4_pkg::t_q16 Q_MAX = 32'sh7FFF_FFFF;
    localparam vt4x4_pkg::t_q16 Q_MIN = 32'sh8000_0000;
    localparam logic signed [vt4x4_pkg::SUM_W-1:0] SAT_HI = 2147483647;
    localparam logic signed [vt4x4_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        vt4x4_pkg::t_q16 x;
        vt4x4_pkg::t_q16 y;
        vt4x4_pkg::t_q16 z;
        vt4x4_pkg::t_q16 w;
        logic ovf;
    } t_vertex_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_mode;
    logic [vt4x4_pkg::IDX_W-1:0]   i_row_index;
    logic [vt4x4_pkg::IDX_W-1:0]   i_col_index;
    vt4x4_pkg::t_q16               i_load_value;
    vt4x4_pkg::t_q16               i_vec_x;
    vt4x4_pkg::t_q16               i_vec_y;
    vt4x4_pkg::t_q16               i_vec_z;
    vt4x4_pkg::t_q16               i_vec_w;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    vt4x4_pkg::t_q16               o_out_x;
    vt4x4_pkg::t_q16               o_out_y;
    vt4x4_pkg::t_q16               o_out_z;
    vt4x4_pkg::t_q16               o_out_w;
    logic                          o_overflow;

    vt4x4_pkg::t_q16 matrix_shadow [vt4x4_pkg::DIM][vt4x4_pkg::DIM];
    t_vertex_result  expected_vertices [$];
    t_vertex_result  want;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int errors         = 0;
    int n_loads        = 0;
    int n_transforms   = 0;
    int n_results      = 0;
    int n_saturated    = 0;

    vertex_transform_4x4 DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_load_value (i_load_value),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_vec_w      (i_vec_w),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_w      (o_out_w),
        .o_overflow   (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // row vector times matrix, exact sum, round half up, saturate
    function automatic t_vertex_result transform_vertex(vt4x4_pkg::t_q16 vx,
                                                        vt4x4_pkg::t_q16 vy,
                                                        vt4x4_pkg::t_q16 vz,
                                                        vt4x4_pkg::t_q16 vw);
        vt4x4_pkg::t_q16                         vec [vt4x4_pkg::DIM];
        vt4x4_pkg::t_q16                         comp [vt4x4_pkg::DIM];
        logic signed [vt4x4_pkg::PROD_W-1:0]     prod;
        logic signed [vt4x4_pkg::SUM_W-1:0]      acc;
        t_vertex_result                          res;
        vec[0] = vx;
        vec[1] = vy;
        vec[2] = vz;
        vec[3] = vw;
        res.ovf = 1'b0;
        for (int c = 0; c < vt4x4_pkg::DIM; c++) begin
            acc = '0;
            for (int r = 0; r < vt4x4_pkg::DIM; r++) begin
                prod = $signed(vec[r]) * $signed(matrix_shadow[r][c]);
                acc = acc + prod;
            end
            acc = (acc + 32768) >>> vt4x4_pkg::FRAC_W;
            if (acc > SAT_HI) begin
                acc = SAT_HI;
                res.ovf = 1'b1;
            end else if (acc < SAT_LO) begin
                acc = SAT_LO;
                res.ovf = 1'b1;
            end
            comp[c] = vt4x4_pkg::t_q16'(acc[vt4x4_pkg::DATA_W-1:0]);
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.w = comp[3];
        return res;
    endfunction

    function automatic vt4x4_pkg::t_q16 rand_q16();
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return vt4x4_pkg::t_q16'($urandom());
            default: return vt4x4_pkg::t_q16'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    task automatic send_request(input logic mode, input logic [vt4x4_pkg::IDX_W-1:0] row,
                                input logic [vt4x4_pkg::IDX_W-1:0] col,
                                input vt4x4_pkg::t_q16 load,
                                input vt4x4_pkg::t_q16 vx, input vt4x4_pkg::t_q16 vy,
                                input vt4x4_pkg::t_q16 vz, input vt4x4_pkg::t_q16 vw);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_row_index  <= row;
        i_col_index  <= col;
        i_load_value <= load;
        i_vec_x      <= vx;
        i_vec_y      <= vy;
        i_vec_z      <= vz;
        i_vec_w      <= vw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (mode == vt4x4_pkg::MODE_LOAD) begin
            matrix_shadow[row][col] = load;
            n_loads++;
        end else begin
            expected_vertices.push_back(transform_vertex(vx, vy, vz, vw));
            n_transforms++;
        end
    endtask

    task automatic load_element(input int row, input int col, input vt4x4_pkg::t_q16 value);
        send_request(vt4x4_pkg::MODE_LOAD, vt4x4_pkg::IDX_W'(row), vt4x4_pkg::IDX_W'(col),
                     value,
                     vt4x4_pkg::t_q16'($urandom()), vt4x4_pkg::t_q16'($urandom()),
                     vt4x4_pkg::t_q16'($urandom()), vt4x4_pkg::t_q16'($urandom()));
    endtask

    task automatic transform(input vt4x4_pkg::t_q16 vx, input vt4x4_pkg::t_q16 vy,
                             input vt4x4_pkg::t_q16 vz, input vt4x4_pkg::t_q16 vw);
        send_request(vt4x4_pkg::MODE_TRANSFORM, vt4x4_pkg::IDX_W'($urandom()),
                     vt4x4_pkg::IDX_W'($urandom()),
                     vt4x4_pkg::t_q16'($urandom()), vx, vy, vz, vw);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_vertices.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_zero_matrix();
        transform(Q_MAX, Q_MIN, Q_ONE, 32'sh0000_0001);
        transform(Q_MIN, Q_MAX, -32'sh1, Q_ONE);
    endtask

    task automatic test_directed_cases();
        for (int i = 0; i < vt4x4_pkg::DIM; i++) load_element(i, i, Q_ONE);
        transform(32'sh0003_8000, -32'sh0002_4000, 32'sh0000_0001, Q_ONE);
        transform(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        // overflow in both directions on column 0
        load_element(0, 0, Q_MAX);
        load_element(1, 0, Q_MAX);
        transform(Q_MAX, Q_MAX, '0, '0);
        transform(Q_MIN, Q_MIN, '0, '0);
        // half-LSB ties round toward plus infinity
        load_element(2, 1, 32'sh0000_8000);
        transform('0, '0, 32'sh0000_0001, '0);
        transform('0, '0, -32'sh0000_0001, '0);
        // three-component vertex, w supplied as one
        load_element(3, 0, Q_MIN);
        load_element(3, 3, -Q_MAX);
        transform(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, Q_ONE);
        transform(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        wait_for_results();
    endtask

    task automatic test_random_stream(input int n_items, input int src_pct, input int sink_pct);
        vt4x4_pkg::t_q16 w;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 30) begin
                load_element($urandom_range(3), $urandom_range(3), rand_q16());
            end else begin
                w = ($urandom_range(3) == 0) ? Q_ONE : rand_q16();
                transform(rand_q16(), rand_q16(), rand_q16(), w);
            end
        end
        wait_for_results();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left <= LONG_HOLD;
        for (int i = 0; i < 40; i++) transform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        wait_for_results();
    endtask

    task automatic check_field(input string name, input logic [vt4x4_pkg::DATA_W-1:0] exp_val,
                               input logic [vt4x4_pkg::DATA_W-1:0] act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (hold_left > 0) hold_left <= hold_left - 1;
        i_stall <= (hold_left > 1) || ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (o_overflow === 1'b1) n_saturated++;
            if (expected_vertices.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h %h %h %h %b",
                         $time, o_out_x, o_out_y, o_out_z, o_out_w, o_overflow);
            end else begin
                want = expected_vertices.pop_front();
                check_field("out_x", want.x, o_out_x);
                check_field("out_y", want.y, o_out_y);
                check_field("out_z", want.z, o_out_z);
                check_field("out_w", want.w, o_out_w);
                check_field("overflow", vt4x4_pkg::DATA_W'(want.ovf),
                            vt4x4_pkg::DATA_W'(o_overflow));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int r = 0; r < vt4x4_pkg::DIM; r++)
            for (int c = 0; c < vt4x4_pkg::DIM; c++)
                matrix_shadow[r][c] = '0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= vt4x4_pkg::MODE_LOAD;
        i_row_index  <= '0;
        i_col_index  <= '0;
        i_load_value <= '0;
        i_vec_x      <= '0;
        i_vec_y      <= '0;
        i_vec_z      <= '0;
        i_vec_w      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_matrix();
        test_directed_cases();
        test_random_stream(300, 32, 64);
        test_random_stream(300, 64, 32);
        test_random_stream(300, 0, 0);
        test_backpressure();

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d loads and %0d transforms; checked %0d results, %0d saturated,",
                 n_loads, n_transforms, n_results, n_saturated);
        $display("under sender gaps, receiver stalls and one long receiver hold-off.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/vt4x4_pkg.sv
hdl/vt4x4_mstore.sv
hdl/vt4x4_lane.sv
hdl/vt4x4_merge.sv
hdl/vertex_transform_4x4.sv
dv/testbench.sv
